/* rtl/core/ptb_pkg.sv */
// Package for the periodic timer bank: item payload types, action and status
// codes, and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  localparam int ID_W     = 4;
  localparam int PERIOD_W = 16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [ID_W-1:0]       timer_id;
    logic [PERIOD_W-1:0]   period_ticks;
  } in_item_t;

  typedef struct packed {
    logic    expired;
    status_t status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic tick_step;
    logic finish;
  } ptb_cmd_t;

  typedef struct packed {
    action_t action;
    logic    tick_last;
  } ptb_stat_t;

endpackage

`default_nettype wire

/* rtl/core/periodic_timer_bank.sv */
// Top level of the periodic timer bank: controller plus datapath.
// Depends on ptb_pkg, ptb_ctrl and ptb_dp.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    in_data  (in_item_t)
//   output   out_valid / out_ready  out_data (out_item_t)
//
// Add, query and clear-all pass from acceptance through S_EXEC to the output
// register. A tick passes through S_EXEC, S_TICK, S_DRAIN and S_DONE; in
// S_TICK the count memory is walked one channel per cycle through its single
// read port, with the write-back following in the next cycle.
// Reset clears the live and expired flags at once; the memories need no pass.
// A finished result waits in the output register while the next item is
// accepted; that item completes once the register is free.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ptb_cmd_t  cmd;
  ptb_stat_t stat;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptb_dp #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_data (in_data),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

/* rtl/core/ptb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/ptb_ctrl.sv */
// Controller of the periodic timer bank: sequences one item at a time and
// owns the output valid flag. Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptb_ctrl
  import ptb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ptb_stat_t stat,
  output ptb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.tick_step = 1'b0;
    cmd.finish    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.action == ACT_TICK) begin
          state_next = S_TICK;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.tick_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptb_dp.sv */
// Datapath of the periodic timer bank: item register, live and expired flags,
// count and period memories, tick walk and result register.
// Depends on ptb_pkg and ptb_ram.
`timescale 1ns / 1ps
`default_nettype none

module ptb_dp
  import ptb_pkg::*;
#(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  ptb_cmd_t  cmd,
  output ptb_stat_t stat,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XW   = (CH_W > ID_W) ? CH_W : ID_W;

  in_item_t              item;
  logic [CHANNELS-1:0]   live;
  logic [CHANNELS-1:0]   flag;
  logic [CH_W-1:0]       walk_idx;
  logic [CH_W-1:0]       wb_idx;
  logic                  wb_valid;
  logic [XW-1:0]         id_ext;
  logic [CH_W-1:0]       id_idx;
  logic                  id_ok;
  logic [COUNT_BITS-1:0] period_sat;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] reload_q;
  logic [COUNT_BITS-1:0] rem_dec;
  logic                  wb_live;
  logic                  wb_hit;
  logic                  add_ok;
  out_item_t             result;
  logic                  rem_we;
  logic [CH_W-1:0]       rem_waddr;
  logic [COUNT_BITS-1:0] rem_wdata;

  assign id_ext = XW'(item.timer_id);
  assign id_idx = id_ext[CH_W-1:0];
  assign id_ok  = (32'(item.timer_id) < 32'(CHANNELS));

  generate
    if (COUNT_BITS >= PERIOD_W) begin : g_wide
      assign period_sat = COUNT_BITS'(item.period_ticks);
    end else begin : g_narrow
      assign period_sat = (|item.period_ticks[PERIOD_W-1:COUNT_BITS]) ?
                          {COUNT_BITS{1'b1}} : item.period_ticks[COUNT_BITS-1:0];
    end
  endgenerate

  assign stat.action    = item.action;
  assign stat.tick_last = (walk_idx == CH_W'(CHANNELS - 1));

  assign rem_dec = rem_q - COUNT_BITS'(1);
  assign wb_live = live[wb_idx];
  assign wb_hit  = wb_valid && wb_live;

  always_comb begin
    result.expired = 1'b0;
    result.status  = ST_OK;
    add_ok         = 1'b0;
    case (item.action)
      ACT_ADD: begin
        if (!id_ok) begin
          result.status = ST_UNKNOWN;
        end else if (live[id_idx]) begin
          result.status = ST_DUP;
        end else if (item.period_ticks == '0) begin
          result.status = ST_ZERO;
        end else begin
          add_ok = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (!id_ok) begin
          result.status = ST_UNKNOWN;
        end else if (!live[id_idx]) begin
          result.status = ST_UNKNOWN;
        end else begin
          result.expired = flag[id_idx];
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = wb_idx;
    rem_wdata = (rem_dec == '0) ? reload_q : rem_dec;
    if (cmd.finish && add_ok) begin
      rem_we    = 1'b1;
      rem_waddr = id_idx;
      rem_wdata = period_sat;
    end else if (wb_hit) begin
      rem_we = 1'b1;
    end
  end

  ptb_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(CHANNELS)
  ) u_remaining (
    .clk  (clk),
    .we   (rem_we),
    .waddr(rem_waddr),
    .wdata(rem_wdata),
    .raddr(walk_idx),
    .rdata(rem_q)
  );

  ptb_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(CHANNELS)
  ) u_reload (
    .clk  (clk),
    .we   (cmd.finish && add_ok),
    .waddr(id_idx),
    .wdata(period_sat),
    .raddr(walk_idx),
    .rdata(reload_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.finish) begin
      out_data <= result;
    end
    if (cmd.capture) begin
      walk_idx <= '0;
    end else if (cmd.tick_step) begin
      walk_idx <= walk_idx + CH_W'(1);
    end
    wb_idx <= walk_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      flag     <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.tick_step;
      if (wb_hit && (rem_dec == '0)) begin
        flag[wb_idx] <= 1'b1;
      end
      if (cmd.finish) begin
        case (item.action)
          ACT_ADD: begin
            if (add_ok) begin
              live[id_idx] <= 1'b1;
              flag[id_idx] <= 1'b0;
            end
          end
          ACT_QUERY: begin
            if (result.status == ST_OK) begin
              flag[id_idx] <= 1'b0;
            end
          end
          ACT_CLEAR: begin
            live <= '0;
            flag <= '0;
          end
          default: begin
            live <= live;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
